// ===== rtl/piecewise_linear_table_interp_top_macros.svh =====
// Assertion macros for the piecewise-linear table block.
`ifndef PIECEWISE_LINEAR_TABLE_INTERP_TOP_MACROS_SVH
`define PIECEWISE_LINEAR_TABLE_INTERP_TOP_MACROS_SVH

// Same-cycle implication, off while in reset.
`define PLTI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while in reset.
`define PLTI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/plti_pkg.sv =====
// Shared constants and types of the piecewise-linear table block.
package plti_pkg;

  localparam int XW       = 32;  // Q16.16 word
  localparam int DW       = 33;  // abscissa difference
  localparam int PW       = 65;  // product
  localparam int SW       = 66;  // sum of products
  localparam int DIV_STEPS = 32;
  localparam int DIV_CW   = 5;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_EVAL   = 2'd2;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_FEW   = 3'd1;
  localparam logic [2:0] ST_ORDER = 3'd2;
  localparam logic [2:0] ST_FULL  = 3'd3;
  localparam logic [2:0] ST_SAT   = 3'd4;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_DIFF,
    OP_MUL0,
    OP_MUL1,
    OP_ADD,
    OP_ABS,
    OP_CHECK,
    OP_DIV
  } op_t;

  typedef struct packed {
    op_t  op;
    logic load_lo;
    logic load_hi;
  } arith_ctl_t;

  typedef struct packed {
    logic          big;
    logic          div_last;
    logic          sat;
    logic [XW-1:0] value;
  } arith_sts_t;

endpackage

// ===== rtl/piecewise_linear_table_interp_top.sv =====
// Clear, append and a short evaluate answer in the cycle after the request is
// accepted; a full evaluate walks the segment index through the single table
// read port, then runs the 32-step shared divider, which stops at once when the
// quotient overflows 32 bits. One request at a time; the next is taken once the
// previous result is taken. Synchronous reset empties the table and zeroes the
// segment index; the breakpoint memories are not cleared.
`include "piecewise_linear_table_interp_top_macros.svh"

module piecewise_linear_table_interp_top #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  logic [1:0]                     command,
  input  logic signed [plti_pkg::XW-1:0] x,
  input  logic signed [plti_pkg::XW-1:0] y,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output logic signed [plti_pkg::XW-1:0] value,
  output logic [2:0]                     status
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DN_RD, S_DN_CMP, S_UP_RD, S_UP_CMP, S_LD0, S_LD1, S_LD2,
    S_DIFF, S_MUL0, S_MUL1, S_ADD, S_ABS, S_CHECK, S_DIV, S_FIN
  } state_t;

  state_t                         state;
  logic [CW-1:0]                  count;
  logic [AW-1:0]                  seg;
  logic signed [plti_pkg::XW-1:0] q;
  logic signed [plti_pkg::XW-1:0] last_x;

  logic                           accept;
  logic                           eval_go;
  logic                           rsp_now;
  logic                           wr_en;
  logic [AW-1:0]                  rd_addr;
  logic signed [plti_pkg::XW-1:0] rd_x, rd_y;
  logic [CW-1:0]                  seg_ext;
  logic [CW-1:0]                  top_c;
  logic                           full;
  plti_pkg::arith_ctl_t           ctl;
  plti_pkg::arith_sts_t           sts;

  assign req_ready = (state == S_IDLE) && (!rsp_valid || rsp_ready);
  assign accept    = req_valid && req_ready;
  assign eval_go   = accept && (command == plti_pkg::CMD_EVAL) && (count >= CW'(2));
  // every accepted request but a full evaluate answers at once
  assign rsp_now   = accept && !eval_go;
  assign seg_ext   = CW'(seg);
  assign top_c     = count - CW'(2);
  assign full      = count >= CW'(TABLE_DEPTH);
  assign wr_en     = accept && (command == plti_pkg::CMD_APPEND) && !full &&
                     ((count == '0) || (x > last_x));

  always_comb begin
    case (state)
      S_UP_RD, S_LD1: rd_addr = seg + AW'(1);
      default:        rd_addr = seg;
    endcase
  end

  always_comb begin
    ctl.op      = plti_pkg::OP_NONE;
    ctl.load_lo = state == S_LD1;
    ctl.load_hi = state == S_LD2;
    case (state)
      S_DIFF:  ctl.op = plti_pkg::OP_DIFF;
      S_MUL0:  ctl.op = plti_pkg::OP_MUL0;
      S_MUL1:  ctl.op = plti_pkg::OP_MUL1;
      S_ADD:   ctl.op = plti_pkg::OP_ADD;
      S_ABS:   ctl.op = plti_pkg::OP_ABS;
      S_CHECK: ctl.op = plti_pkg::OP_CHECK;
      S_DIV:   ctl.op = plti_pkg::OP_DIV;
      default: ctl.op = plti_pkg::OP_NONE;
    endcase
  end

  plti_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[AW-1:0]),
    .wr_x    (x),
    .wr_y    (y),
    .rd_addr (rd_addr),
    .rd_x    (rd_x),
    .rd_y    (rd_y)
  );

  plti_arith u_arith (
    .clk  (clk),
    .ctl  (ctl),
    .q    (q),
    .rd_x (rd_x),
    .rd_y (rd_y),
    .sts  (sts)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      seg       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && !rsp_now) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            value <= '0;
            case (command)
              plti_pkg::CMD_CLEAR: begin
                count     <= '0;
                seg       <= '0;
                status    <= plti_pkg::ST_OK;
                rsp_valid <= 1'b1;
              end
              plti_pkg::CMD_APPEND: begin
                rsp_valid <= 1'b1;
                if (full) begin
                  status <= plti_pkg::ST_FULL;
                end else if (!wr_en) begin
                  status <= plti_pkg::ST_ORDER;
                end else begin
                  status <= plti_pkg::ST_OK;
                  last_x <= x;
                  count  <= count + 1'b1;
                end
              end
              plti_pkg::CMD_EVAL: begin
                if (count < CW'(2)) begin
                  status    <= plti_pkg::ST_FEW;
                  rsp_valid <= 1'b1;
                end else begin
                  q     <= x;
                  state <= S_DN_RD;
                end
              end
              default: begin
                status    <= plti_pkg::ST_OK;
                rsp_valid <= 1'b1;
              end
            endcase
          end
        end
        S_DN_RD: state <= S_DN_CMP;
        S_DN_CMP: begin
          if ((seg != '0) && (rd_x > q)) begin
            seg   <= seg - 1'b1;
            state <= S_DN_RD;
          end else begin
            state <= S_UP_RD;
          end
        end
        S_UP_RD: state <= S_UP_CMP;
        S_UP_CMP: begin
          if ((seg_ext < top_c) && (q > rd_x)) begin
            seg   <= seg + 1'b1;
            state <= S_UP_RD;
          end else begin
            state <= S_LD0;
          end
        end
        S_LD0:   state <= S_LD1;
        S_LD1:   state <= S_LD2;
        S_LD2:   state <= S_DIFF;
        S_DIFF:  state <= S_MUL0;
        S_MUL0:  state <= S_MUL1;
        S_MUL1:  state <= S_ADD;
        S_ADD:   state <= S_ABS;
        S_ABS:   state <= S_CHECK;
        S_CHECK: state <= S_DIV;
        S_DIV: begin
          // an oversized quotient needs no divide
          if (sts.big || sts.div_last) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          value     <= sts.value;
          status    <= sts.sat ? plti_pkg::ST_SAT : plti_pkg::ST_OK;
          rsp_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PLTI_ASSERT_NOW(a_busy_no_rsp, state != S_IDLE, !rsp_valid, "result held while evaluating")
  `PLTI_ASSERT_NOW(a_count_range, 1'b1, count <= CW'(TABLE_DEPTH), "point count beyond depth")
  `PLTI_ASSERT_NOW(a_seg_range, count >= CW'(2), seg_ext <= top_c, "segment index past end")
  `PLTI_ASSERT_NEXT(a_eval_walk, eval_go, state == S_DN_RD, "evaluate did not start the walk")

endmodule

// ===== rtl/plti_table.sv =====
// Breakpoint memories: one write port, one registered read port.
module plti_table #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [$clog2(TABLE_DEPTH)-1:0]       wr_addr,
  input  logic signed [plti_pkg::XW-1:0]       wr_x,
  input  logic signed [plti_pkg::XW-1:0]       wr_y,
  input  logic [$clog2(TABLE_DEPTH)-1:0]       rd_addr,
  output logic signed [plti_pkg::XW-1:0]       rd_x,
  output logic signed [plti_pkg::XW-1:0]       rd_y
);

  logic signed [plti_pkg::XW-1:0] x_mem [TABLE_DEPTH];
  logic signed [plti_pkg::XW-1:0] y_mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      x_mem[wr_addr] <= wr_x;
      y_mem[wr_addr] <= wr_y;
    end
    rd_x <= x_mem[rd_addr];
    rd_y <= y_mem[rd_addr];
  end

endmodule

// ===== rtl/plti_arith.sv =====
// Shared interpolation datapath: differences, one multiplier, sum, magnitude, serial divide.
module plti_arith (
  input  logic                            clk,
  input  plti_pkg::arith_ctl_t            ctl,
  input  logic signed [plti_pkg::XW-1:0]  q,
  input  logic signed [plti_pkg::XW-1:0]  rd_x,
  input  logic signed [plti_pkg::XW-1:0]  rd_y,
  output plti_pkg::arith_sts_t            sts
);

  logic signed [plti_pkg::XW-1:0] x0, y0, x1, y1;
  logic signed [plti_pkg::DW-1:0] da, db;
  logic [plti_pkg::XW-1:0]        d;
  logic signed [plti_pkg::PW-1:0] prod;
  logic signed [plti_pkg::SW-1:0] acc;
  logic                           neg;
  logic                           big;
  logic [plti_pkg::XW-1:0]        rem;
  logic [plti_pkg::XW-1:0]        dvd;   // low dividend bits out, quotient bits in
  logic [plti_pkg::DIV_CW-1:0]    cnt;

  logic signed [plti_pkg::XW-1:0] mul_a;
  logic signed [plti_pkg::DW-1:0] mul_b;
  logic signed [plti_pkg::PW-1:0] mul_out;
  logic [plti_pkg::XW:0]          div_t;
  logic [plti_pkg::XW:0]          div_diff;
  logic                           div_ge;
  logic [plti_pkg::XW-1:0]        div_rem;

  assign mul_a   = (ctl.op == plti_pkg::OP_MUL0) ? y0 : y1;
  assign mul_b   = (ctl.op == plti_pkg::OP_MUL0) ? da : db;
  assign mul_out = mul_a * mul_b;

  assign div_t    = {rem, dvd[plti_pkg::XW-1]};
  assign div_ge   = div_t >= {1'b0, d};
  assign div_diff = div_t - {1'b0, d};
  assign div_rem  = div_ge ? div_diff[plti_pkg::XW-1:0] : div_t[plti_pkg::XW-1:0];

  always_ff @(posedge clk) begin
    if (ctl.load_lo) begin
      x0 <= rd_x;
      y0 <= rd_y;
    end
    if (ctl.load_hi) begin
      x1 <= rd_x;
      y1 <= rd_y;
    end
    case (ctl.op)
      plti_pkg::OP_DIFF: begin
        da <= {x1[plti_pkg::XW-1], x1} - {q[plti_pkg::XW-1], q};
        db <= {q[plti_pkg::XW-1], q} - {x0[plti_pkg::XW-1], x0};
        d  <= x1 - x0;   // x strictly increasing, so the wrapped difference is exact
      end
      plti_pkg::OP_MUL0: prod <= mul_out;
      plti_pkg::OP_MUL1: begin
        prod <= mul_out;
        acc  <= {prod[plti_pkg::PW-1], prod};
      end
      plti_pkg::OP_ADD: acc <= acc + {prod[plti_pkg::PW-1], prod};
      plti_pkg::OP_ABS: begin
        neg <= acc[plti_pkg::SW-1];
        if (acc[plti_pkg::SW-1]) begin
          acc <= -acc;
        end
      end
      plti_pkg::OP_CHECK: begin
        // quotient fits 32 bits only if the upper dividend half is below d
        big <= acc[plti_pkg::SW-2:plti_pkg::XW] >= {1'b0, d};
        rem <= acc[2*plti_pkg::XW-1:plti_pkg::XW];
        dvd <= acc[plti_pkg::XW-1:0];
        cnt <= '0;
      end
      plti_pkg::OP_DIV: begin
        rem <= div_rem;
        dvd <= {dvd[plti_pkg::XW-2:0], div_ge};
        cnt <= cnt + 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    sts.big      = big;
    sts.div_last = cnt == plti_pkg::DIV_CW'(plti_pkg::DIV_STEPS - 1);
    if (neg) begin
      sts.sat   = big || (dvd > 32'h8000_0000);
      sts.value = sts.sat ? 32'h8000_0000 : (~dvd + 1'b1);
    end else begin
      sts.sat   = big || dvd[plti_pkg::XW-1];
      sts.value = sts.sat ? 32'h7FFF_FFFF : dvd;
    end
  end

endmodule

// ===== tb/sv/tb_piecewise_linear_table_interp_top.sv =====
// Testbench for the piecewise-linear breakpoint table: directed and random requests.
module tb_piecewise_linear_table_interp_top;

  localparam int          TABLE_DEPTH = 256;
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam int          CYCLE_LIMIT = 10000000;
  localparam int          DRAIN_WAIT  = 600;
  localparam logic signed [31:0] Q_MAX32 = 32'sh7FFFFFFF;
  localparam logic signed [31:0] Q_MIN32 = 32'sh80000000;
  localparam longint      Q_MAX64 = 64'sd2147483647;
  localparam longint      Q_MIN64 = -64'sd2147483648;

  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         status;
  } lut_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_ready;
  logic [1:0]         command = plti_pkg::CMD_CLEAR;
  logic signed [31:0] x = '0;
  logic signed [31:0] y = '0;
  logic               rsp_valid;
  logic               rsp_ready = 1'b0;
  logic signed [31:0] rsp_value;
  logic [2:0]         rsp_status;

  // Own copy of the table
  logic signed [31:0] tbl_x [TABLE_DEPTH];
  logic signed [31:0] tbl_y [TABLE_DEPTH];
  int unsigned        tbl_count = 0;
  int unsigned        seg_idx = 0;

  lut_result_t pending_results[$];
  int          error_count = 0;
  int          sent_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  piecewise_linear_table_interp_top #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .command   (command),
    .x         (x),
    .y         (y),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .value     (rsp_value),
    .status    (rsp_status)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(negedge clk) begin
    rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Exact interpolation on segment seg, quotient truncated toward zero
  function automatic lut_result_t lut_interpolate(int unsigned seg, logic signed [31:0] q);
    lut_result_t        res;
    logic signed [127:0] xa, xb, ya, yb, qq, num, span, quo;
    xa = tbl_x[seg];
    xb = tbl_x[seg + 1];
    ya = tbl_y[seg];
    yb = tbl_y[seg + 1];
    qq = q;
    num = ya * (xb - qq) + yb * (qq - xa);
    span = xb - xa;
    quo = num / span;
    res.status = plti_pkg::ST_OK;
    if (quo > 128'sd2147483647) begin
      res.value = Q_MAX32;
      res.status = plti_pkg::ST_SAT;
    end else if (quo < -(128'sd2147483648)) begin
      res.value = Q_MIN32;
      res.status = plti_pkg::ST_SAT;
    end else begin
      res.value = quo[31:0];
    end
    return res;
  endfunction

  function automatic lut_result_t predict_lut(logic [1:0] cmd, logic signed [31:0] xv,
                                              logic signed [31:0] yv);
    lut_result_t res;
    int unsigned top_seg, i;
    res.value = '0;
    res.status = plti_pkg::ST_OK;
    case (cmd)
      plti_pkg::CMD_CLEAR: begin
        tbl_count = 0;
        seg_idx = 0;
      end
      plti_pkg::CMD_APPEND: begin
        // full check takes precedence over ordering
        if (tbl_count >= TABLE_DEPTH) begin
          res.status = plti_pkg::ST_FULL;
        end else if (tbl_count > 0 && xv <= tbl_x[tbl_count - 1]) begin
          res.status = plti_pkg::ST_ORDER;
        end else begin
          tbl_x[tbl_count] = xv;
          tbl_y[tbl_count] = yv;
          tbl_count++;
        end
      end
      plti_pkg::CMD_EVAL: begin
        if (tbl_count < 2) begin
          res.status = plti_pkg::ST_FEW;
        end else begin
          top_seg = tbl_count - 2;
          i = (seg_idx > top_seg) ? top_seg : seg_idx;
          while (i > 0 && tbl_x[i] > xv) i--;
          while (i < top_seg && xv > tbl_x[i + 1]) i++;
          seg_idx = i;
          res = lut_interpolate(i, xv);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    lut_result_t exp_res;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result value %h status %0d", $time, rsp_value, rsp_status);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (rsp_value !== exp_res.value) begin
          $display("%0t: value expected %h actual %h", $time, exp_res.value, rsp_value);
          error_count++;
        end
        if (rsp_status !== exp_res.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_res.status, rsp_status);
          error_count++;
        end
      end
    end
  end

  // Called and returns at a falling edge
  task automatic send_request(logic [1:0] cmd, logic signed [31:0] xv, logic signed [31:0] yv);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    command <= cmd;
    x <= xv;
    y <= yv;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    pending_results.push_back(predict_lut(cmd, xv, yv));
    sent_count++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  task automatic test_empty_table();
    send_request(plti_pkg::CMD_EVAL, 32'sd0, 32'sd0);
    send_request(plti_pkg::CMD_APPEND, 32'sd0, 32'sh00010000);
    send_request(plti_pkg::CMD_EVAL, 32'sd0, 32'sd0);
    send_request(plti_pkg::CMD_APPEND, 32'sd0, 32'sd5);
    send_request(CMD_UNUSED, 32'shFFFFFFFF, 32'shFFFFFFFF);
  endtask

  task automatic test_extremes();
    send_request(plti_pkg::CMD_CLEAR, 32'sd0, 32'sd0);
    send_request(plti_pkg::CMD_APPEND, Q_MIN32, Q_MIN32);
    send_request(plti_pkg::CMD_APPEND, Q_MAX32, Q_MAX32);
    send_request(plti_pkg::CMD_EVAL, Q_MIN32, 32'sd0);
    send_request(plti_pkg::CMD_EVAL, Q_MAX32, 32'sd0);
    // steep segment: extrapolation saturates both ways, ends are exact
    send_request(plti_pkg::CMD_CLEAR, 32'sd0, 32'sd0);
    send_request(plti_pkg::CMD_APPEND, 32'sd0, Q_MIN32);
    send_request(plti_pkg::CMD_APPEND, 32'sd1, Q_MAX32);
    send_request(plti_pkg::CMD_EVAL, 32'sd100, 32'sd0);
    send_request(plti_pkg::CMD_EVAL, -32'sd100, 32'sd0);
    send_request(plti_pkg::CMD_EVAL, 32'sd0, 32'sd0);
    send_request(plti_pkg::CMD_EVAL, 32'sd1, 32'sd0);
  endtask

  task automatic test_segment_walk();
    send_request(plti_pkg::CMD_CLEAR, 32'sd0, 32'sd0);
    send_request(plti_pkg::CMD_APPEND, 32'sd0, 32'sd0);
    send_request(plti_pkg::CMD_APPEND, 32'sh00010000, 32'sh00020000);
    send_request(plti_pkg::CMD_APPEND, 32'sh00020000, -32'sh00010000);
    send_request(plti_pkg::CMD_APPEND, 32'sh00030000, 32'sh00030000);
    send_request(plti_pkg::CMD_EVAL, 32'sh00038000, 32'sd0);
    send_request(plti_pkg::CMD_EVAL, -32'sh00008000, 32'sd0);
    send_request(plti_pkg::CMD_EVAL, 32'sh00018000, 32'sd0);
    send_request(plti_pkg::CMD_EVAL, 32'sh00010000, 32'sd0);
  endtask

  // Clear, then append up to npts points with rising x; a few are out of order
  task automatic build_random_table(int unsigned npts);
    int unsigned        step_max, k;
    int                 scale;
    bit                 small_y;
    longint             nxt;
    logic signed [31:0] xv, yv;
    scale = $urandom_range(0, 3);
    small_y = $urandom_range(0, 1);
    case (scale)
      0: step_max = 4;
      1: step_max = 65536;
      2: step_max = 16777216;
      default: step_max = 32'h80000000;
    endcase
    send_request(plti_pkg::CMD_CLEAR, $urandom, $urandom);
    for (k = 0; k < npts; k++) begin
      yv = small_y ? ($urandom_range(0, 32'h000FFFFF) - 32'sh00080000) : $urandom;
      if (tbl_count == 0) begin
        if (scale == 3)
          xv = Q_MIN32 + $urandom_range(0, 1000);
        else
          xv = $urandom;
      end else if ($urandom_range(0, 19) == 0) begin
        xv = tbl_x[tbl_count - 1] - $urandom_range(0, 2);
      end else begin
        nxt = longint'(tbl_x[tbl_count - 1]) + longint'($urandom_range(1, step_max));
        if (nxt > Q_MAX64) break;
        xv = nxt[31:0];
      end
      send_request(plti_pkg::CMD_APPEND, xv, yv);
    end
  endtask

  task automatic run_random_queries(int unsigned n);
    int unsigned        k, idx;
    int                 kind;
    longint             lo, hi, span, qv;
    longint unsigned    r64, modv;
    logic signed [31:0] xv;
    for (k = 0; k < n; k++) begin
      kind = (tbl_count == 0) ? 0 : $urandom_range(0, 3);
      xv = $urandom;
      if (kind == 1 || kind == 3) begin
        idx = $urandom_range(0, tbl_count - 1);
        xv = tbl_x[idx];
        if (kind == 3) xv = xv + (($urandom_range(0, 1) == 0) ? 32'sd1 : -32'sd1);
      end else if (kind == 2) begin
        // mostly inside the table, with some way past either end
        lo = tbl_x[0];
        hi = tbl_x[tbl_count - 1];
        span = hi - lo + 1;
        modv = span + span / 2 + 1;
        r64 = {$urandom, $urandom};
        qv = lo - span / 4 + longint'(r64 % modv);
        if (qv > Q_MAX64) qv = Q_MAX64;
        if (qv < Q_MIN64) qv = Q_MIN64;
        xv = qv[31:0];
      end
      send_request(plti_pkg::CMD_EVAL, xv, $urandom);
    end
  endtask

  task automatic test_random_tables(int target);
    int start_count, r;
    start_count = sent_count;
    while (sent_count - start_count < target) begin
      if ($urandom_range(0, 49) == 0) wait_drained();
      r = $urandom_range(0, 99);
      if (r < 6) begin
        send_request(2'($urandom_range(0, 3)), $urandom, $urandom);
      end else if (r < 10) begin
        build_random_table($urandom_range(0, 1));
        run_random_queries(2);
      end else if (r < 18) begin
        build_random_table($urandom_range(2, 48));
        run_random_queries($urandom_range(4, 12));
      end else begin
        build_random_table($urandom_range(2, 8));
        run_random_queries($urandom_range(1, 8));
      end
    end
  endtask

  task automatic test_full_table();
    int unsigned k;
    send_request(plti_pkg::CMD_CLEAR, 32'sd0, 32'sd0);
    send_request(plti_pkg::CMD_APPEND, Q_MIN32 + $urandom_range(0, 1000), $urandom);
    for (k = 1; k < TABLE_DEPTH; k++)
      send_request(plti_pkg::CMD_APPEND,
                   tbl_x[tbl_count - 1] + $urandom_range(1, 8000000), $urandom);
    // full wins over ordering here
    send_request(plti_pkg::CMD_APPEND, tbl_x[0], $urandom);
    send_request(plti_pkg::CMD_APPEND, Q_MAX32, $urandom);
    send_request(plti_pkg::CMD_EVAL, Q_MAX32, 32'sd0);
    send_request(plti_pkg::CMD_EVAL, Q_MIN32, 32'sd0);
    run_random_queries(6);
    send_request(plti_pkg::CMD_EVAL, tbl_x[TABLE_DEPTH - 1], 32'sd0);
    send_request(plti_pkg::CMD_CLEAR, 32'sd0, 32'sd0);
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_table();
    test_extremes();
    test_segment_walk();

    send_idle_pct = 8;
    recv_idle_pct = 88;
    test_random_tables(220);

    wait_drained();
    send_idle_pct = 88;
    recv_idle_pct = 8;
    test_random_tables(220);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_tables(220);
    test_full_table();

    wait_drained();
    repeat (DRAIN_WAIT) @(negedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
